### src/gf4096_mul_inv_div_unit_top_assert.svh
// Assertion macros of the GF(2^12) unit, used by gfmid_out.
// Needs a clk_i and an active-low rst_ni in the scope where a macro is used.
`ifndef GF4096_MUL_INV_DIV_UNIT_TOP_ASSERT_SVH
`define GF4096_MUL_INV_DIV_UNIT_TOP_ASSERT_SVH

`ifndef SYNTH
// Checked on every rising clock edge, suspended while reset is asserted.
`define GFMID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define GFMID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define GFMID_ASSERT(lbl, prop, msg)
`define GFMID_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/gfmid_pkg.sv
// Types, constants and GF(2^12) arithmetic functions of the unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none

package gfmid_pkg;

  localparam int unsigned FieldBits = 12;
  localparam int unsigned ProdBits  = 2 * FieldBits - 1;

  // Operation codes carried in tuser.
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_INV = 2'd1,
    OP_DIV = 2'd2
  } gfmid_op_e;

  // Where a cell takes its second multiplicand from.
  localparam logic [1:0] SRC_SELF = 2'd0;  // the cell's own input before squaring
  localparam logic [1:0] SRC_E2   = 2'd1;  // a^3, saved by the first cell
  localparam logic [1:0] SRC_A    = 2'd2;  // the operand itself

  // Addition chain for a^(4094): each cell squares NSQ times, then multiplies.
  localparam int unsigned CellCount = 5;
  localparam int unsigned CellNsq [CellCount] = '{1, 2, 4, 2, 1};
  localparam logic [1:0]  CellSrc [CellCount] = '{SRC_SELF, SRC_SELF, SRC_SELF,
                                                  SRC_E2, SRC_A};

  // One request as it moves along the row of cells.
  typedef struct packed {
    logic [1:0]           op;
    logic [FieldBits-1:0] a;
    logic [FieldBits-1:0] b;
    logic [FieldBits-1:0] e2;
    logic [FieldBits-1:0] r;
  } gfmid_item_t;

  // Reduce a product of up to 23 bits modulo x^12 + x^3 + 1.
  function automatic logic [FieldBits-1:0] gf_reduce(input logic [ProdBits-1:0] p_in);
    logic [ProdBits-1:0] p;
    logic [ProdBits-1:0] hi;
    p  = p_in;
    hi = p & 23'h7FC000;
    p  = p ^ (hi >> 9) ^ (hi >> 12);
    hi = p & 23'h003000;
    p  = p ^ (hi >> 9) ^ (hi >> 12);
    return p[FieldBits-1:0];
  endfunction

  // Carry-less multiply followed by reduction.
  function automatic logic [FieldBits-1:0] gf_mul(input logic [FieldBits-1:0] x,
                                                 input logic [FieldBits-1:0] y);
    logic [ProdBits-1:0] acc;
    acc = '0;
    for (int i = 0; i < FieldBits; i++) begin
      acc = acc ^ (({{(FieldBits-1){1'b0}}, x} << i) & {ProdBits{y[i]}});
    end
    return gf_reduce(acc);
  endfunction

  // Squaring spreads the bits to even positions, then reduces.
  function automatic logic [FieldBits-1:0] gf_sq(input logic [FieldBits-1:0] x);
    logic [ProdBits-1:0] p;
    p = '0;
    for (int i = 0; i < FieldBits; i++) begin
      p[2*i] = x[i];
    end
    return gf_reduce(p);
  endfunction

endpackage

`default_nettype wire

### src/gf4096_mul_inv_div_unit_top.sv
// GF(2^12) multiply / invert / divide unit, polynomial x^12 + x^3 + 1.
// A request passes the chain cells, then the output register. Throughput when
// the master does not stall: one request per cycle; each of the five chain cells
// and the output stage does one field multiply per cycle and hands its request on.
// Reset clears only the valid flags of the cells and of the output stage.
// Depends on gfmid_pkg, gfmid_cell and gfmid_out.
`default_nettype none

module gf4096_mul_inv_div_unit_top
  import gfmid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request side.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // [11:0] operand_a, [23:12] operand_b
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  // Result side.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [11:0] field_result, [15:12] zero
);

  logic                 valid_w [CellCount+1];
  logic                 ready_w [CellCount+1];
  gfmid_item_t          item_w  [CellCount+1];
  logic [FieldBits-1:0] result_w;

  // Form the request; the chain starts from a itself.
  always_comb begin
    item_w[0].op = s_axis_tuser_i;
    item_w[0].a  = s_axis_tdata_i[11:0];
    item_w[0].b  = s_axis_tdata_i[23:12];
    item_w[0].e2 = '0;
    item_w[0].r  = s_axis_tdata_i[11:0];
  end

  assign valid_w[0]      = s_axis_tvalid_i;
  assign s_axis_tready_o = ready_w[0];

  // Row of chain cells.
  for (genvar g = 0; g < CellCount; g++) begin : g_cell
    gfmid_cell #(
      .Idx(g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_w[g]),
      .in_ready_o  (ready_w[g]),
      .in_item_i   (item_w[g]),
      .out_valid_o (valid_w[g+1]),
      .out_ready_i (ready_w[g+1]),
      .out_item_o  (item_w[g+1])
    );
  end

  // Final squaring, operation select and result register.
  gfmid_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_w[CellCount]),
    .in_ready_o   (ready_w[CellCount]),
    .in_item_i    (item_w[CellCount]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_result_o (result_w)
  );

  assign m_axis_tdata_o = {4'b0000, result_w};

endmodule

`default_nettype wire

### src/gfmid_cell.sv
// One cell of the inversion chain: square a few times, multiply, register.
// Depends on gfmid_pkg for the item type, the chain tables and the field functions.
`default_nettype none

module gfmid_cell
  import gfmid_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire gfmid_item_t in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output gfmid_item_t      out_item_o
);

  logic                 valid_q;
  gfmid_item_t          item_q;
  gfmid_item_t          item_d;
  logic [FieldBits-1:0] sq_val;
  logic [FieldBits-1:0] opnd;
  logic [FieldBits-1:0] prod;

  // The cell takes a new request when it is empty or its content moves on.
  assign in_ready_o = !valid_q || out_ready_i;

  // Repeated squaring of the incoming partial power.
  always_comb begin
    sq_val = in_item_i.r;
    for (int k = 0; k < CellNsq[Idx]; k++) begin
      sq_val = gf_sq(sq_val);
    end
  end

  // Pick the second multiplicand for this step of the chain.
  always_comb begin
    if (CellSrc[Idx] == SRC_E2) begin
      opnd = in_item_i.e2;
    end else if (CellSrc[Idx] == SRC_A) begin
      opnd = in_item_i.a;
    end else begin
      opnd = in_item_i.r;
    end
  end

  assign prod = gf_mul(sq_val, opnd);

  // The first cell produces a^3, which a later cell needs again.
  always_comb begin
    item_d    = in_item_i;
    item_d.r  = prod;
    if (Idx == 0) begin
      item_d.e2 = prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

### src/gfmid_out.sv
// Last cell: final squaring, operation select and the registered result port.
// Depends on gfmid_pkg and on the assertion macro header.
`default_nettype none

`include "gf4096_mul_inv_div_unit_top_assert.svh"

module gfmid_out
  import gfmid_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire gfmid_item_t          in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [FieldBits-1:0]      out_result_o
);

  logic                 valid_q;
  logic [FieldBits-1:0] result_q;
  logic [FieldBits-1:0] result_d;
  logic [FieldBits-1:0] inv_val;
  logic [FieldBits-1:0] mul_x;
  logic [FieldBits-1:0] mul_y;
  logic                 in_fire;

  assign in_ready_o = !valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // The chain ends with one more squaring, giving a^4094.
  assign inv_val = gf_sq(in_item_i.r);

  // A multiply uses a, an inverse multiplies by one, a divide uses the inverse and b.
  always_comb begin
    mul_x    = inv_val;
    mul_y    = in_item_i.b;
    result_d = '0;
    unique case (in_item_i.op)
      OP_MUL: begin
        mul_x    = in_item_i.a;
        result_d = gf_mul(mul_x, mul_y);
      end
      OP_INV: begin
        mul_y    = {{(FieldBits-1){1'b0}}, 1'b1};
        result_d = gf_mul(mul_x, mul_y);
      end
      OP_DIV: begin
        result_d = gf_mul(mul_x, mul_y);
      end
      default: begin
        result_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

  // An unused operation code gives a zero result.
  `GFMID_ASSERT(a_rsv_zero, in_fire && in_item_i.op != OP_MUL && in_item_i.op != OP_INV && in_item_i.op != OP_DIV |=> out_result_o == '0, "unused operation code gave a nonzero result")
  // The inverse of zero is zero.
  `GFMID_ASSERT(a_inv_zero, in_fire && in_item_i.op == OP_INV && in_item_i.a == '0 |=> out_result_o == '0, "inverse of zero is not zero")
  // A product with a zero factor is zero.
  `GFMID_ASSERT(a_mul_zero, in_fire && in_item_i.op == OP_MUL && (in_item_i.a == '0 || in_item_i.b == '0) |=> out_result_o == '0, "product with zero factor is not zero")
  // An empty output register always takes a request.
  `GFMID_ASSERT_ALWAYS(a_empty_ready, !out_valid_o |-> in_ready_o, "empty output stage refused a request")

endmodule

`default_nettype wire

### test/gf4096_result_checker.sv
// Checker for the GF(2^12) multiply / invert / divide unit: predicts each result and compares.
// Watches both stream channels of the unit; takes the operation codes from gfmid_pkg.
`timescale 1ns / 100ps
`default_nettype none

module gf4096_result_checker
  import gfmid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request channel as seen at the unit's slave side.
  input  wire logic        req_valid_i,
  input  wire logic        req_ready_i,
  input  wire logic [23:0] req_data_i,     // [11:0] operand_a, [23:12] operand_b
  input  wire logic [1:0]  req_user_i,     // [1:0] req_type
  // Result channel as seen at the unit's master side.
  input  wire logic        res_valid_i,
  input  wire logic        res_ready_i,
  input  wire logic [15:0] res_data_i,     // [11:0] field_result, [15:12] zero
  output int unsigned      mismatch_count_o,
  output int unsigned      outstanding_o,
  output int unsigned      checked_o
);

  // x^12 = x^3 + 1 in the field, so a carry out of bit 11 folds back here.
  localparam logic [11:0] FoldBack    = 12'h009;
  // Inversion is a^(2^12 - 2).
  localparam logic [11:0] InvExponent = 12'hFFE;

  logic [11:0] expected_results [$];
  int unsigned errors = 0;

  // Horner-style multiply: shift the accumulator by x, fold the carry, add x when y has the bit.
  function automatic logic [11:0] field_product(input logic [11:0] x, input logic [11:0] y);
    logic [11:0] acc;
    acc = '0;
    for (int i = 11; i >= 0; i--) begin
      acc = {acc[10:0], 1'b0} ^ (acc[11] ? FoldBack : 12'h000);
      if (y[i]) acc = acc ^ x;
    end
    return acc;
  endfunction

  // Left-to-right square-and-multiply; zero comes out as zero.
  function automatic logic [11:0] field_inverse(input logic [11:0] x);
    logic [11:0] acc;
    acc = 12'h001;
    for (int i = 11; i >= 0; i--) begin
      acc = field_product(acc, acc);
      if (InvExponent[i]) acc = field_product(acc, x);
    end
    return acc;
  endfunction

  // The element one request should produce; an undefined operation gives zero.
  function automatic logic [11:0] field_outcome(input logic [1:0] op, input logic [11:0] a,
                                                input logic [11:0] b);
    case (op)
      OP_MUL:  return field_product(a, b);
      OP_INV:  return field_inverse(a);
      OP_DIV:  return field_product(field_inverse(a), b);
      default: return 12'h000;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input logic [15:0] got);
    errors++;
    $display("%0t ns: %s: expected %03h, got %04h", $time, what, want, got);
  endtask

  // Results are matched before new requests are queued, so a result can never
  // consume the prediction of a request taken at the same edge.
  always @(posedge clk_i) begin : watch_channels
    logic [11:0] want;
    if (rst_ni) begin
      if (res_valid_i && res_ready_i) begin
        checked_o <= checked_o + 1;
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no request waiting", 0, res_data_i);
        end else begin
          want = expected_results.pop_front();
          if (res_data_i[11:0] !== want) begin
            flag_mismatch("field_result", want, res_data_i);
          end
          if (res_data_i[15:12] !== 4'h0) begin
            flag_mismatch("padding bits", 0, res_data_i);
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_results.push_back(field_outcome(req_user_i, req_data_i[11:0],
                                                 req_data_i[23:12]));
      end
      outstanding_o    <= expected_results.size();
      mismatch_count_o <= errors;
    end
  end

endmodule

`default_nettype wire

### test/testbench.sv
// Top of the GF(2^12) unit testbench: clock, reset, request and result traffic, verdict.
// Instantiates gf4096_mul_inv_div_unit_top and gf4096_result_checker; uses gfmid_pkg.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import gfmid_pkg::*;

  // The one operation code the unit does not define.
  localparam logic [1:0]  OpUnused      = 2'd3;
  localparam int unsigned RandomCount   = 1400;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned TailCycles    = 20;

  logic        clk;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic [23:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned checked;

  // Request mix and hold-off bookkeeping for the summary.
  int unsigned op_sent [4] = '{0, 0, 0, 0};
  int unsigned sent_total = 0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_offs_done = 0;
  int unsigned idle_cycles = 0;

  gf4096_mul_inv_div_unit_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  gf4096_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .req_valid_i      (s_valid),
    .req_ready_i      (s_ready),
    .req_data_i       (s_data),
    .req_user_i       (s_user),
    .res_valid_i      (m_valid),
    .res_ready_i      (m_ready),
    .res_data_i       (m_data),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding),
    .checked_o        (checked)
  );

  // 12 ns clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reset is asserted at the start and released once.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Watchdog: ends the run when no request and no result moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("%0t ns: no traffic for %0d cycles", $time, StallLimit);
        $display("testbench failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Field element biased toward zero, one, all ones and single bits.
  function automatic logic [11:0] draw_element();
    case ($urandom_range(7))
      0:       return 12'h000;
      1:       return 12'h001;
      2:       return 12'hFFF;
      3:       return 12'h001 << $urandom_range(11);
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // Offers one request after an optional gap and waits until it is taken.
  task automatic send_request(input logic [1:0] op, input logic [11:0] a,
                              input logic [11:0] b, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(15);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {b, a};
    s_user  <= op;
    do @(posedge clk); while (!s_ready);
    op_sent[op]++;
    sent_total++;
  endtask

  // Result side: random stalls, full-speed stretches, and long hold-offs on demand.
  initial begin : result_sink
    int unsigned wait_cycles;
    int unsigned taken;
    taken = 0;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        m_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end
      wait_cycles = ((taken / 64) % 3 == 2) ? 0 : $urandom_range(15);
      if (wait_cycles > 0) begin
        m_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
      taken++;
    end
  end

  // Request side: directed corner cases, then random traffic, then drain and verdict.
  initial begin : request_source
    logic [1:0]  op;
    int unsigned pick;
    bit          full_speed;
    wait (rst_n);
    @(posedge clk);

    // Multiply: zeros, ones, all ones, top bit squared, alternating patterns.
    send_request(OP_MUL, 12'h000, 12'hFFF, 1'b0);
    send_request(OP_MUL, 12'hFFF, 12'h000, 1'b0);
    send_request(OP_MUL, 12'h001, 12'h001, 1'b0);
    send_request(OP_MUL, 12'hFFF, 12'hFFF, 1'b0);
    send_request(OP_MUL, 12'h800, 12'h800, 1'b0);
    send_request(OP_MUL, 12'h001, 12'hFFF, 1'b0);
    send_request(OP_MUL, 12'h555, 12'hAAA, 1'b0);
    send_request(OP_MUL, 12'hAAA, 12'h555, 1'b0);
    // Inverse: of zero, of one, of the extremes, with the ignored operand set.
    send_request(OP_INV, 12'h000, 12'h000, 1'b0);
    send_request(OP_INV, 12'h000, 12'hFFF, 1'b0);
    send_request(OP_INV, 12'h001, 12'h000, 1'b0);
    send_request(OP_INV, 12'hFFF, 12'hFFF, 1'b0);
    send_request(OP_INV, 12'h800, 12'h000, 1'b0);
    send_request(OP_INV, 12'h002, 12'hABC, 1'b0);
    // Divide: by zero, of zero, by one, an element by itself.
    send_request(OP_DIV, 12'h000, 12'hFFF, 1'b0);
    send_request(OP_DIV, 12'h000, 12'h000, 1'b0);
    send_request(OP_DIV, 12'h123, 12'h000, 1'b0);
    send_request(OP_DIV, 12'h001, 12'hFFF, 1'b0);
    send_request(OP_DIV, 12'hFFF, 12'hFFF, 1'b0);
    send_request(OP_DIV, 12'h800, 12'h001, 1'b0);
    // Undefined operation code must still give one zero result.
    send_request(OpUnused, 12'hFFF, 12'hFFF, 1'b0);
    send_request(OpUnused, 12'h000, 12'h000, 1'b0);

    // Random part; two windows run at full speed against a long result hold-off.
    for (int i = 0; i < RandomCount; i++) begin
      if (i == 300 || i == 900) hold_off_req = 1'b1;
      full_speed = ((i / 50) % 3 == 1) || (i >= 300 && i < 360) || (i >= 900 && i < 960);
      pick = $urandom_range(99);
      if (pick < 5) op = OpUnused;
      else if (pick < 37) op = OP_MUL;
      else if (pick < 68) op = OP_INV;
      else op = OP_DIV;
      send_request(op, draw_element(), draw_element(), full_speed);
    end
    s_valid <= 1'b0;
    @(posedge clk);

    // Drain; the watchdog catches a result that never comes.
    while (outstanding != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d requests: %0d multiply, %0d inverse, %0d divide, %0d undefined.",
             sent_total, op_sent[OP_MUL], op_sent[OP_INV], op_sent[OP_DIV], op_sent[OpUnused]);
    $display("Compared %0d results with %0d mismatches; %0d long result hold-offs applied.",
             checked, mismatch_count, hold_offs_done);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
